@@ src/acrl_pkg.sv @@
// shared types and constants for the associative cache with lru or random replacement
package acrl_pkg;

  localparam int KEY_W      = 16;
  localparam int PAY_W      = 32;
  localparam int STAMP_W    = 32;
  localparam int SLOT_W     = 4;
  localparam int LFSR_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // lfsr start value used at reset and for a zero seed
  localparam logic [LFSR_W-1:0] SEED_DEFAULT = 16'd44257;
  localparam logic [LFSR_W-1:0] LFSR_TAPS    = 16'hB400;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED  = 2'd1;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic {
    REPL_RANDOM = 1'b0,
    REPL_LRU    = 1'b1
  } repl_e;

  // control from the sequencer to the random victim unit
  typedef struct packed {
    logic              start;
    logic              seed_we;
    logic [LFSR_W-1:0] seed;
  } rand_ctl_t;

endpackage

@@ src/acrl_rand.sv @@
// random victim unit: galois lfsr and reciprocal reduction modulo the entry count
module acrl_rand #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  acrl_pkg::rand_ctl_t        ctl_i,
  output logic                       busy_o,
  output logic [$clog2(ENTRIES)-1:0] victim_o
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int LW  = acrl_pkg::LFSR_W;
  // quotient by multiply and shift, exact for every lfsr value
  localparam int RSH = LW + IW;
  localparam int RW  = LW + 2;
  localparam int PW  = LW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << RSH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
  localparam logic [LW-1:0] ENT_K = LW'(ENTRIES);

  logic [LW-1:0] lfsr_q, lfsr_d, lfsr_next;
  logic [LW-1:0] quot_q, quot_d;
  logic [IW-1:0] rem_q, rem_d;
  logic          phase_q, phase_d;
  logic          busy_q, busy_d;
  logic [PW-1:0] prod;
  logic [LW-1:0] back;

  // one galois step, shifting right
  always_comb begin
    lfsr_next = lfsr_q >> 1;
    if (lfsr_q[0]) begin
      lfsr_next = lfsr_next ^ acrl_pkg::LFSR_TAPS;
    end
  end

  // quotient from the reciprocal, remainder from the registered quotient
  assign prod = PW'(lfsr_q) * PW'(RECIP);
  assign back = quot_q * ENT_K;

  always_comb begin
    lfsr_d  = lfsr_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    if (ctl_i.seed_we) begin
      lfsr_d = (ctl_i.seed == '0) ? acrl_pkg::SEED_DEFAULT : ctl_i.seed;
    end else if (ctl_i.start) begin
      lfsr_d  = lfsr_next;
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (!phase_q) begin
        quot_d  = LW'(prod >> RSH);
        phase_d = 1'b1;
      end else begin
        rem_d   = IW'(lfsr_q - back);
        phase_d = 1'b0;
        busy_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q  <= acrl_pkg::SEED_DEFAULT;
      phase_q <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      lfsr_q  <= lfsr_d;
      phase_q <= phase_d;
      busy_q  <= busy_d;
    end
  end

  // quotient and remainder registers are payload
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o   = busy_q;
  assign victim_o = rem_q;

endmodule

@@ src/assoc_cache_lru_random_top.sv @@
// top level of the fully associative cache with lru or random replacement
//
// Usage: items arrive on the in channel (opcode, key, payload) and are
// taken at an edge with in_valid_i high and in_stall_o low. Each item gives
// exactly one result on the out channel, taken at an edge with out_valid_o
// high and out_stall_i low. in_stall_o stays high while an item is at work.
// Operation: a lookup reads the entries one per cycle through the registered
// read port and stops at the first match, or skips the scan on an empty
// store; an insert into a non-full store writes the next free entry; a
// full-store insert scans all stamps in lru mode and takes the victim of the
// random unit in random mode.
// Configuration: writes on the cfg channel are always taken (cfg_ready_o is
// high); index 0 selects replacement (0 random, 1 lru), index 1 loads the
// lfsr seed. Write it only while no item is in flight.
// Reset: empties the store, clears the access clock, selects lru mode and
// loads the default seed. No memory clearing pass is needed.
// Stall: a finished result waits in the output register; the next item is
// accepted meanwhile and its result is held back until the register frees.
module assoc_cache_lru_random_top #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic [acrl_pkg::KEY_W-1:0]       key_i,
  input  logic [acrl_pkg::PAY_W-1:0]       payload_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [acrl_pkg::PAY_W-1:0]       hit_payload_o,
  output logic [acrl_pkg::SLOT_W-1:0]      slot_o,
  output logic                             evicted_o,
  output logic [acrl_pkg::PAY_W-1:0]       evicted_payload_o,
  // configuration channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [acrl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [acrl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW:0] ENT_C = (IW + 1)'(ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RAND = 3'd2;
  localparam logic [2:0] S_RDV  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // entry memories
  logic [acrl_pkg::KEY_W-1:0]   key_mem   [ENTRIES];
  logic [acrl_pkg::PAY_W-1:0]   data_mem  [ENTRIES];
  logic [acrl_pkg::STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [acrl_pkg::KEY_W-1:0]   rd_key_q;
  logic [acrl_pkg::PAY_W-1:0]   rd_data_q;
  logic [acrl_pkg::STAMP_W-1:0] rd_stamp_q;
  logic [IW-1:0]                rd_addr;
  logic                         we_entry, we_stamp;

  // control state
  logic [2:0]                   state_q, state_d;
  acrl_pkg::repl_e              mode_q, mode_d;
  logic [IW:0]                  fill_q, fill_d;
  logic [acrl_pkg::STAMP_W-1:0] clock_q, clock_d;
  logic [IW:0]                  rd_idx_q, rd_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic                         out_valid_q, out_valid_d;

  // item and result registers
  acrl_pkg::op_e                op_q, op_d;
  logic [acrl_pkg::KEY_W-1:0]   key_q, key_d;
  logic [acrl_pkg::PAY_W-1:0]   pay_q, pay_d;
  logic [IW-1:0]                cmp_idx_q, cmp_idx_d;
  logic                         hit_q, hit_d;
  logic [acrl_pkg::PAY_W-1:0]   hit_data_q, hit_data_d;
  logic [IW-1:0]                slot_q, slot_d;
  logic                         evict_q, evict_d;
  logic [acrl_pkg::PAY_W-1:0]   ev_data_q, ev_data_d;
  logic [acrl_pkg::STAMP_W-1:0] best_stamp_q, best_stamp_d;

  // output register
  logic                         o_hit_q, o_evict_q;
  logic [acrl_pkg::PAY_W-1:0]   o_hit_data_q, o_ev_data_q;
  logic [IW-1:0]                o_slot_q;
  logic                         out_load;

  logic                         in_xfer;
  logic [IW:0]                  scan_limit;
  logic                         issue;
  logic                         rand_start;
  acrl_pkg::rand_ctl_t          rand_ctl;
  logic                         rand_busy;
  logic [IW-1:0]                rand_victim;

  acrl_rand #(
    .ENTRIES (ENTRIES)
  ) u_rand (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rand_ctl),
    .busy_o   (rand_busy),
    .victim_o (rand_victim)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;

  // scan bound: filled entries for a lookup, all entries for an lru victim
  assign scan_limit = (op_q == acrl_pkg::OP_LOOKUP) ? fill_q : ENT_C;
  assign issue      = (state_q == S_SCAN) && (rd_idx_q < scan_limit);

  // configuration decode
  always_comb begin
    mode_d           = mode_q;
    rand_ctl.start   = rand_start;
    rand_ctl.seed_we = 1'b0;
    rand_ctl.seed    = cfg_data_i;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        acrl_pkg::CFG_REPLACE_MODE: mode_d = acrl_pkg::repl_e'(cfg_data_i[0]);
        acrl_pkg::CFG_RANDOM_SEED:  rand_ctl.seed_we = 1'b1;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    clock_d        = clock_q;
    rd_idx_d       = rd_idx_q;
    cmp_vld_d      = 1'b0;
    cmp_idx_d      = rd_idx_q[IW-1:0];
    op_d           = op_q;
    key_d          = key_q;
    pay_d          = pay_q;
    hit_d          = hit_q;
    hit_data_d     = hit_data_q;
    slot_d         = slot_q;
    evict_d        = evict_q;
    ev_data_d      = ev_data_q;
    best_stamp_d   = best_stamp_q;
    rd_addr        = rd_idx_q[IW-1:0];
    we_entry       = 1'b0;
    we_stamp       = 1'b0;
    rand_start     = 1'b0;
    out_load       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d       = acrl_pkg::op_e'(opcode_i);
          key_d      = key_i;
          pay_d      = payload_i;
          clock_d    = (clock_q == '1) ? clock_q : clock_q + 1'b1;
          rd_idx_d   = '0;
          hit_d      = 1'b0;
          hit_data_d = '0;
          slot_d     = '0;
          evict_d    = 1'b0;
          ev_data_d  = '0;
          if (acrl_pkg::op_e'(opcode_i) == acrl_pkg::OP_LOOKUP) begin
            state_d = (fill_q == '0) ? S_OUT : S_SCAN;
          end else if (fill_q < ENT_C) begin
            slot_d  = fill_q[IW-1:0];
            fill_d  = fill_q + 1'b1;
            state_d = S_WR;
          end else if (mode_q == acrl_pkg::REPL_RANDOM) begin
            rand_start = 1'b1;
            state_d    = S_RAND;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one read a cycle, compare the entry from the registered read port
        if (issue) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          cmp_vld_d = 1'b1;
        end
        if (cmp_vld_q) begin
          if (op_q == acrl_pkg::OP_LOOKUP) begin
            if (rd_key_q == key_q) begin
              hit_d      = 1'b1;
              hit_data_d = rd_data_q;
              slot_d     = cmp_idx_q;
              cmp_vld_d  = 1'b0;
              state_d    = S_WR;
            end
          end else if (cmp_idx_q == '0 || rd_stamp_q < best_stamp_q) begin
            best_stamp_d = rd_stamp_q;
            slot_d       = cmp_idx_q;
            ev_data_d    = rd_data_q;
          end
        end
        if (!issue && !cmp_vld_q) begin
          if (op_q == acrl_pkg::OP_LOOKUP) begin
            state_d = S_OUT;
          end else begin
            evict_d = 1'b1;
            state_d = S_WR;
          end
        end
      end

      S_RAND: begin
        rd_addr = rand_victim;
        if (!rand_busy) begin
          slot_d  = rand_victim;
          state_d = S_RDV;
        end
      end

      S_RDV: begin
        evict_d   = 1'b1;
        ev_data_d = rd_data_q;
        state_d   = S_WR;
      end

      S_WR: begin
        we_stamp = 1'b1;
        we_entry = (op_q == acrl_pkg::OP_INSERT);
        state_d  = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output valid follows loads and transfers
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= acrl_pkg::REPL_LRU;
      fill_q      <= '0;
      clock_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      fill_q      <= fill_d;
      clock_q     <= clock_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_q        <= hit_d;
    hit_data_q   <= hit_data_d;
    slot_q       <= slot_d;
    evict_q      <= evict_d;
    ev_data_q    <= ev_data_d;
    best_stamp_q <= best_stamp_d;
    if (out_load) begin
      o_hit_q      <= hit_q;
      o_hit_data_q <= hit_data_q;
      o_slot_q     <= slot_q;
      o_evict_q    <= evict_q;
      o_ev_data_q  <= ev_data_q;
    end
  end

  // entry memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_entry) begin
      key_mem[slot_q]  <= key_q;
      data_mem[slot_q] <= pay_q;
    end
    if (we_stamp) begin
      stamp_mem[slot_q] <= clock_q;
    end
    rd_key_q   <= key_mem[rd_addr];
    rd_data_q  <= data_mem[rd_addr];
    rd_stamp_q <= stamp_mem[rd_addr];
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = o_hit_q;
  assign hit_payload_o     = o_hit_data_q;
  assign slot_o            = acrl_pkg::SLOT_W'(o_slot_q);
  assign evicted_o         = o_evict_q;
  assign evicted_payload_o = o_ev_data_q;

endmodule

@@ src/acrl_chk.sv @@
// port-level assertions for the associative cache top level and their bind
module acrl_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            hit_o,
  input logic [acrl_pkg::PAY_W-1:0]      hit_payload_o,
  input logic                            evicted_o,
  input logic [acrl_pkg::PAY_W-1:0]      evicted_payload_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item at a time: an accepted item blocks the next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // a result never shows both a hit and an eviction
  a_hit_xor_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction in one result");

  // no hit means a zero hit payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_payload_o == '0)
    else $error("nonzero payload without a hit");

  // no eviction means a zero evicted payload
  a_noevict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_payload_o == '0)
    else $error("nonzero evicted payload without an eviction");

endmodule

bind assoc_cache_lru_random_top acrl_chk u_acrl_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .hit_o             (hit_o),
  .hit_payload_o     (hit_payload_o),
  .evicted_o         (evicted_o),
  .evicted_payload_o (evicted_payload_o)
);

@@ bench/tb_assoc_cache_lru_random_top.sv @@
// self-checking testbench for the associative cache with lru or random replacement
`timescale 1ns / 1ps

module tb_assoc_cache_lru_random_top;

  localparam int ENTRIES    = 16;
  localparam int CLK_PERIOD = 20;
  localparam int IDLE_PCT   = 36;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 40;
  localparam int STALL_CAP  = 4000;

  // register indexes with no register behind them
  localparam logic [acrl_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [acrl_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  typedef struct packed {
    logic                        hit;
    logic [acrl_pkg::PAY_W-1:0]  hit_payload;
    logic [acrl_pkg::SLOT_W-1:0] slot;
    logic                        evicted;
    logic [acrl_pkg::PAY_W-1:0]  evicted_payload;
  } outcome_t;

  typedef struct {
    acrl_pkg::op_e              op;
    logic [acrl_pkg::KEY_W-1:0] key;
    logic [acrl_pkg::PAY_W-1:0] payload;
    bit                         typed;
    outcome_t                   want;
  } row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            opcode_i = 1'b0;
  logic [acrl_pkg::KEY_W-1:0]      key_i = '0;
  logic [acrl_pkg::PAY_W-1:0]      payload_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            hit_o;
  logic [acrl_pkg::PAY_W-1:0]      hit_payload_o;
  logic [acrl_pkg::SLOT_W-1:0]     slot_o;
  logic                            evicted_o;
  logic [acrl_pkg::PAY_W-1:0]      evicted_payload_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [acrl_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [acrl_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // mirror of the cache contents and control state
  acrl_pkg::repl_e              mirror_mode;
  logic [acrl_pkg::LFSR_W-1:0]  mirror_lfsr;
  int                           mirror_fill;
  logic [acrl_pkg::KEY_W-1:0]   mirror_key [ENTRIES];
  logic [acrl_pkg::PAY_W-1:0]   mirror_pay [ENTRIES];
  logic [acrl_pkg::STAMP_W-1:0] mirror_stamp [ENTRIES];
  logic [acrl_pkg::STAMP_W-1:0] access_tick;

  outcome_t expected_results [$];
  row_t     script [$];

  bit calm;
  bit hold_req;
  int hold_left;
  int mismatch_count;
  int items_sent;
  int results_checked;
  int hit_count;
  int lru_evictions;
  int random_evictions;
  int quiet_cycles;

  assoc_cache_lru_random_top #(.ENTRIES(ENTRIES)) dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // cache behavior: one access, returns the outcome it must produce
  function automatic void cache_access(input acrl_pkg::op_e op,
                                       input logic [acrl_pkg::KEY_W-1:0] key,
                                       input logic [acrl_pkg::PAY_W-1:0] pay,
                                       output outcome_t res);
    int  idx;
    bit  found;
    found = 1'b0;
    res = '0;
    if (access_tick != '1) access_tick++;
    if (op == acrl_pkg::OP_LOOKUP) begin
      // first matching filled entry wins
      for (int i = 0; i < mirror_fill; i++) begin
        if (!found && mirror_key[i] == key) begin
          found = 1'b1;
          res.hit = 1'b1;
          res.hit_payload = mirror_pay[i];
          res.slot = i[acrl_pkg::SLOT_W-1:0];
          mirror_stamp[i] = access_tick;
        end
      end
    end else begin
      if (mirror_fill < ENTRIES) begin
        idx = mirror_fill;
        mirror_fill++;
      end else begin
        if (mirror_mode == acrl_pkg::REPL_RANDOM) begin
          // galois step, shift right
          if (mirror_lfsr[0]) mirror_lfsr = (mirror_lfsr >> 1) ^ acrl_pkg::LFSR_TAPS;
          else mirror_lfsr = mirror_lfsr >> 1;
          idx = int'(mirror_lfsr) % ENTRIES;
          random_evictions++;
        end else begin
          // oldest stamp, lowest index on ties
          idx = 0;
          for (int i = 1; i < ENTRIES; i++)
            if (mirror_stamp[i] < mirror_stamp[idx]) idx = i;
          lru_evictions++;
        end
        res.evicted = 1'b1;
        res.evicted_payload = mirror_pay[idx];
      end
      res.slot = idx[acrl_pkg::SLOT_W-1:0];
      mirror_key[idx] = key;
      mirror_pay[idx] = pay;
      mirror_stamp[idx] = access_tick;
    end
  endfunction

  function automatic outcome_t outcome(input logic h, input logic [acrl_pkg::PAY_W-1:0] hp,
                                       input logic [acrl_pkg::SLOT_W-1:0] s, input logic e,
                                       input logic [acrl_pkg::PAY_W-1:0] ep);
    outcome_t o;
    o.hit = h;
    o.hit_payload = hp;
    o.slot = s;
    o.evicted = e;
    o.evicted_payload = ep;
    return o;
  endfunction

  function automatic void add_row(input acrl_pkg::op_e op,
                                  input logic [acrl_pkg::KEY_W-1:0] key,
                                  input logic [acrl_pkg::PAY_W-1:0] pay, input bit typed,
                                  input outcome_t want);
    row_t r;
    r.op = op;
    r.key = key;
    r.payload = pay;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endfunction

  function automatic void check_field(input string name,
                                      input logic [acrl_pkg::PAY_W-1:0] want,
                                      input logic [acrl_pkg::PAY_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // offer one item, record its outcome once the transfer happens
  task automatic offer_item(input acrl_pkg::op_e op, input logic [acrl_pkg::KEY_W-1:0] key,
                            input logic [acrl_pkg::PAY_W-1:0] pay, input bit typed,
                            input outcome_t want);
    outcome_t got;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    key_i <= key;
    payload_i <= pay;
    do @(posedge clk_i); while (in_stall_o);
    cache_access(op, key, pay, got);
    expected_results.push_back(typed ? want : got);
    items_sent++;
  endtask

  // register write; the caller lowers valid after the last one
  task automatic cfg_write(input logic [acrl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [acrl_pkg::CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == acrl_pkg::CFG_REPLACE_MODE) begin
      mirror_mode = acrl_pkg::repl_e'(value[0]);
    end else if (idx == acrl_pkg::CFG_RANDOM_SEED) begin
      mirror_lfsr = (value == '0) ? acrl_pkg::SEED_DEFAULT : value;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // one phase of random traffic under a given setting
  task automatic run_phase(input acrl_pkg::repl_e mode, input bit seed_we,
                           input logic [15:0] seed, input bit junk_we, input int count,
                           input bit quiet, input bit squeeze);
    acrl_pkg::op_e              op;
    logic [acrl_pkg::KEY_W-1:0] key;
    int                         pick;
    cfg_write(acrl_pkg::CFG_REPLACE_MODE, {15'd0, mode});
    if (seed_we) cfg_write(acrl_pkg::CFG_RANDOM_SEED, seed);
    if (junk_we) begin
      cfg_write(CFG_UNUSED_A, 16'($urandom));
      cfg_write(CFG_UNUSED_B, 16'($urandom));
    end
    cfg_valid_i <= 1'b0;
    calm = quiet;
    if (squeeze) hold_req = 1'b1;
    repeat (count) begin
      op = $urandom_range(1) ? acrl_pkg::OP_INSERT : acrl_pkg::OP_LOOKUP;
      pick = $urandom_range(99);
      // mostly keys that are present, some from a tiny pool to make duplicates
      if (pick < 60 && mirror_fill > 0) key = mirror_key[$urandom_range(mirror_fill - 1)];
      else if (pick < 75) key = 16'($urandom_range(7));
      else key = 16'($urandom);
      offer_item(op, key, $urandom, 1'b0, '0);
    end
    drain();
    calm = 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (out_valid_o && !out_stall_i) begin
      got = outcome(hit_o, hit_payload_o, slot_o, evicted_o, evicted_payload_o);
      if (expected_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("hit", acrl_pkg::PAY_W'(want.hit), acrl_pkg::PAY_W'(got.hit));
        check_field("hit_payload", want.hit_payload, got.hit_payload);
        check_field("slot", acrl_pkg::PAY_W'(want.slot), acrl_pkg::PAY_W'(got.slot));
        check_field("evicted", acrl_pkg::PAY_W'(want.evicted),
                    acrl_pkg::PAY_W'(got.evicted));
        check_field("evicted_payload", want.evicted_payload, got.evicted_payload);
        if (want.hit) hit_count++;
      end
      results_checked++;
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_CAP) begin
        $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
        $display("assoc_cache_lru_random_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    // reset state of the mirror
    mirror_mode = acrl_pkg::REPL_LRU;
    mirror_lfsr = acrl_pkg::SEED_DEFAULT;
    mirror_fill = 0;
    access_tick = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      mirror_key[i] = '0;
      mirror_pay[i] = '0;
      mirror_stamp[i] = '0;
    end

    // directed rows, lru mode straight out of reset
    add_row(acrl_pkg::OP_LOOKUP, 16'h0000, 32'h0, 1'b1,
            outcome(1'b0, 32'h0, 4'd0, 1'b0, 32'h0));
    add_row(acrl_pkg::OP_INSERT, 16'h0000, 32'h0, 1'b1,
            outcome(1'b0, 32'h0, 4'd0, 1'b0, 32'h0));
    add_row(acrl_pkg::OP_INSERT, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
            outcome(1'b0, 32'h0, 4'd1, 1'b0, 32'h0));
    add_row(acrl_pkg::OP_LOOKUP, 16'hFFFF, 32'hA5A5A5A5, 1'b1,
            outcome(1'b1, 32'hFFFFFFFF, 4'd1, 1'b0, 32'h0));
    // duplicate key lands in a fresh slot, lookup still finds the lower one
    add_row(acrl_pkg::OP_INSERT, 16'hFFFF, 32'h5A5A5A5A, 1'b1,
            outcome(1'b0, 32'h0, 4'd2, 1'b0, 32'h0));
    add_row(acrl_pkg::OP_LOOKUP, 16'hFFFF, 32'h0, 1'b0, '0);
    add_row(acrl_pkg::OP_LOOKUP, 16'h0000, 32'hFFFFFFFF, 1'b0, '0);
    add_row(acrl_pkg::OP_LOOKUP, 16'h1234, 32'h0, 1'b0, '0);
    // fill the remaining slots
    for (int i = 3; i < ENTRIES; i++)
      add_row(acrl_pkg::OP_INSERT, 16'h0100 + 16'(i), {4{8'(i)}}, 1'b0, '0);
    // full store: lru victims
    add_row(acrl_pkg::OP_INSERT, 16'h8000, 32'h80000001, 1'b0, '0);
    add_row(acrl_pkg::OP_LOOKUP, 16'h0000, 32'h0, 1'b0, '0);
    add_row(acrl_pkg::OP_INSERT, 16'h7FFF, 32'h7FFFFFFE, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i])
      offer_item(script[i].op, script[i].key, script[i].payload, script[i].typed,
                 script[i].want);
    drain();

    // random traffic under several settings
    run_phase(acrl_pkg::REPL_RANDOM, 1'b1, 16'd1, 1'b0, 100, 1'b0, 1'b0);
    run_phase(acrl_pkg::REPL_RANDOM, 1'b1, 16'd0, 1'b0, 100, 1'b0, 1'b0);
    run_phase(acrl_pkg::REPL_LRU, 1'b0, 16'd0, 1'b0, 100, 1'b0, 1'b1);
    run_phase(acrl_pkg::REPL_RANDOM, 1'b1, 16'hFFFF, 1'b0, 100, 1'b1, 1'b0);
    run_phase(acrl_pkg::REPL_RANDOM, 1'b1, 16'($urandom), 1'b1, 120, 1'b0, 1'b0);
    run_phase(acrl_pkg::REPL_LRU, 1'b1, 16'($urandom), 1'b0, 100, 1'b0, 1'b0);

    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d items sent, %0d results checked, %0d lookup hits", items_sent,
             results_checked, hit_count);
    $display("%0d lru and %0d random evictions, %0d mismatches", lru_evictions,
             random_evictions, mismatch_count);
    if (mismatch_count == 0) begin
      $display("assoc_cache_lru_random_top: match");
    end else begin
      $display("assoc_cache_lru_random_top: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/acrl_pkg.sv
src/acrl_rand.sv
src/assoc_cache_lru_random_top.sv
src/acrl_chk.sv
bench/tb_assoc_cache_lru_random_top.sv
